// ===== hdl/rlepal_pkg.sv =====
// shared types, codes and constants for the run-length palette image decoder
// used by rlepal_step and rle_palette_image_decoder_top; no dependencies
package rlepal_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int PIX_W    = 17;
    localparam int COLOUR_W = 24;
    localparam int COUNT_W  = 8;

    // configuration register indexes
    localparam logic REG_HEADER_LENGTH = 1'b0;
    localparam logic REG_IMAGE_PIXELS  = 1'b1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] HEADER_LENGTH_RESET = 8'd68;
    localparam logic [PIX_W-1:0]  IMAGE_PIXELS_RESET  = 17'h14000;

    // decode phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CONTROL = 2'd1;
    localparam logic [1:0] PH_RUN     = 2'd2;
    localparam logic [1:0] PH_LITERAL = 2'd3;

    // decoder state carried from item to item
    typedef struct packed {
        logic [1:0]        phase;
        logic [BYTE_W-1:0] header_left;
        logic [BYTE_W-1:0] literal_left;
        logic [BYTE_W-1:0] run_length;
        logic [PIX_W-1:0]  pixels_left;
    } dec_state_t;

    // one decoded result
    typedef struct packed {
        logic                valid;
        logic [COLOUR_W-1:0] colour;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } dec_result_t;

    // fixed 8-bit palette expansion to 24-bit colour
    function automatic logic [COLOUR_W-1:0] expand_colour(input logic [BYTE_W-1:0] idx);
        logic [COLOUR_W-1:0] c;
        c = '0;
        if (idx[7]) c = c + 24'h880000;
        if (idx[6]) c = c + 24'h008800;
        if (idx[5]) c = c + 24'h004400;
        if (idx[4]) c = c + 24'h000088;
        if (idx[3]) c = c + 24'h440000;
        if (idx[2]) c = c + 24'h000044;
        unique case (idx[1:0])
            2'd0: c = c;
            2'd1: c = c + 24'h111111;
            2'd2: c = c + 24'h222222;
            2'd3: c = c + 24'h333333;
            default: c = c;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/rlepal_step.sv =====
// next-state and result logic for one compressed byte
// depends on rlepal_pkg
module rlepal_step
    import rlepal_pkg::*;
(
    input  dec_state_t        cur_state,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              image_start,
    input  logic [BYTE_W-1:0] header_length,
    input  logic [PIX_W-1:0]  image_pixels,
    output dec_state_t        next_state,
    output dec_result_t       result
);

    dec_state_t        st;
    logic              do_control;
    logic              do_emit;
    logic [COUNT_W-1:0] want_count;
    logic [COUNT_W-1:0] emit_count;
    logic [PIX_W-1:0]  pixels_after;
    logic [BYTE_W-1:0] lit_dec;

    // restart on the first byte of a new image
    always_comb begin
        st = cur_state;
        if (image_start) begin
            st.phase        = PH_HEADER;
            st.header_left  = header_length;
            st.literal_left = '0;
            st.run_length   = '0;
            st.pixels_left  = image_pixels;
        end
    end

    // phase handling
    always_comb begin
        next_state = st;
        do_control = 1'b0;
        do_emit    = 1'b0;
        want_count = COUNT_W'(1);
        lit_dec    = (st.literal_left != '0) ? st.literal_left - 8'd1 : '0;
        if (st.pixels_left != '0) begin
            unique case (st.phase)
                PH_HEADER: begin
                    if (st.header_left != '0) begin
                        next_state.header_left = st.header_left - 8'd1;
                        if (st.header_left == 8'd1) next_state.phase = PH_CONTROL;
                    end else begin
                        do_control = 1'b1;
                    end
                end
                PH_CONTROL: begin
                    do_control = 1'b1;
                end
                PH_RUN: begin
                    next_state.phase = PH_CONTROL;
                    do_emit    = 1'b1;
                    want_count = st.run_length;
                end
                PH_LITERAL: begin
                    next_state.literal_left = lit_dec;
                    if (lit_dec == '0) next_state.phase = PH_CONTROL;
                    do_emit = 1'b1;
                end
                default: begin
                    do_control = 1'b1;
                end
            endcase
            // control byte: run or literal header
            if (do_control) begin
                if (data_byte[7]) begin
                    next_state.run_length = {1'b0, data_byte[6:0]} + 8'd2;
                    next_state.phase      = PH_RUN;
                end else begin
                    next_state.literal_left = {1'b0, data_byte[6:0]} + 8'd1;
                    next_state.phase        = PH_LITERAL;
                end
            end
        end
        // count cut to the pixels still owed
        emit_count   = ({{(PIX_W-COUNT_W){1'b0}}, want_count} > st.pixels_left)
                       ? st.pixels_left[COUNT_W-1:0] : want_count;
        pixels_after = st.pixels_left - {{(PIX_W-COUNT_W){1'b0}}, emit_count};
        if (do_emit) next_state.pixels_left = pixels_after;
    end

    // result fields
    always_comb begin
        result.valid  = do_emit;
        result.colour = expand_colour(data_byte);
        result.count  = emit_count;
        result.last   = (pixels_after == '0);
    end

endmodule

// ===== hdl/rle_palette_image_decoder_top.sv =====
// Run-length palette image decoder. One compressed byte is taken per clock cycle
// while s_tready is high: the decoder state updates at the accept edge and a
// result, when the byte causes one, is captured in the output register at that same
// edge and is offered on m_tvalid from the next cycle. s_tready falls only while that
// output register holds a result that m_tready has not yet taken, so the sustained
// rate is one byte per cycle while m_tready keeps up. A run gives one item carrying
// its repeat count; literal bytes give one item each. Register writes take effect at
// the next byte flagged as image start (s_tuser) or at reset.
// depends on rlepal_pkg and rlepal_step
module rle_palette_image_decoder_top
    import rlepal_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // [0] image_start
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [23:0] pixel_colour, [31:24] repeat_count
    output logic                m_tlast,   // last_of_image
    // configuration writes
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [PIX_W-1:0]    cfg_wdata
);

    logic [BYTE_W-1:0]   header_length_reg;
    logic [PIX_W-1:0]    image_pixels_reg;
    dec_state_t          state_reg;
    dec_state_t          state_next;
    dec_result_t         step_res;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_last_reg;
    logic                in_accept;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_length_reg <= HEADER_LENGTH_RESET;
            image_pixels_reg  <= IMAGE_PIXELS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HEADER_LENGTH: header_length_reg <= cfg_wdata[BYTE_W-1:0];
                REG_IMAGE_PIXELS:  image_pixels_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // per-byte decode logic
    rlepal_step u_step (
        .cur_state     (state_reg),
        .data_byte     (s_tdata),
        .image_start   (s_tuser),
        .header_length (header_length_reg),
        .image_pixels  (image_pixels_reg),
        .next_state    (state_next),
        .result        (step_res)
    );

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_HEADER;
            state_reg.header_left  <= HEADER_LENGTH_RESET;
            state_reg.literal_left <= '0;
            state_reg.run_length   <= '0;
            state_reg.pixels_left  <= IMAGE_PIXELS_RESET;
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (in_accept && step_res.valid) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && step_res.valid) begin
            out_colour_reg <= step_res.colour;
            out_count_reg  <= step_res.count;
            out_last_reg   <= step_res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_colour_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // a delivered item never carries a zero count
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:24] != 8'd0))
        else $error("result item with zero repeat count");

    // an item marked last leaves no pixels owed
    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && step_res.valid && step_res.last) |=> (state_reg.pixels_left == '0))
        else $error("last item left pixels outstanding");

    // literal phase always has bytes pending
    a_literal_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_LITERAL) |-> (state_reg.literal_left != '0))
        else $error("literal phase with no literal bytes left");

    // run phase holds a run of at least two
    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_RUN) |-> (state_reg.run_length >= 8'd2))
        else $error("run phase with a run shorter than two");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for rle_palette_image_decoder_top: directed table, then random images
// bytes are decoded by a local model of the decoder and results are compared in order
// depends on rlepal_pkg and the decoder rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlepal_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int BODY_TARGET   = 500;
    localparam int CALM_FROM     = 420;

    // one decoded run as seen on the result stream
    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } pixel_run_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_WRITE} row_kind_e;

    // one line of the directed table
    typedef struct {
        row_kind_e         kind;
        logic [PIX_W-1:0]  value;
        logic              start;
        logic              reg_idx;
        logic              has_run;
        pixel_run_t        run;
    } script_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] data_byte
    logic                s_tuser;   // [0] image_start
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;   // [23:0] pixel_colour, [31:24] repeat_count
    logic                m_tlast;   // last_of_image
    logic                cfg_we;
    logic                cfg_addr;
    logic [PIX_W-1:0]    cfg_wdata;

    // decoder model state and register copies
    logic [1:0]          dec_phase;
    logic [7:0]          hdr_left;
    logic [7:0]          lit_left;
    logic [7:0]          run_len;
    logic [PIX_W-1:0]    pix_left;
    logic [7:0]          cfg_hdr_len;
    logic [PIX_W-1:0]    cfg_pix_total;

    pixel_run_t          pending_runs[$];
    script_row_t         script[$];
    int                  error_count;
    int                  body_items;
    int                  cycle_count;
    bit                  idle_on;
    bit                  start_pending;
    bit                  hold_go;

    rle_palette_image_decoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // palette index to rgb: each lane gets two weighted bits plus the grey level
    function automatic logic [23:0] palette_rgb(input logic [7:0] idx);
        logic [7:0] grey;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        grey  = 8'h11 * idx[1:0];
        red   = (idx[7] ? 8'h88 : 8'h00) + (idx[3] ? 8'h44 : 8'h00) + grey;
        green = (idx[6] ? 8'h88 : 8'h00) + (idx[5] ? 8'h44 : 8'h00) + grey;
        blue  = (idx[4] ? 8'h88 : 8'h00) + (idx[2] ? 8'h44 : 8'h00) + grey;
        return {red, green, blue};
    endfunction

    // new image: registers are picked up here
    function automatic void restart_image();
        dec_phase = PH_HEADER;
        hdr_left  = cfg_hdr_len;
        lit_left  = '0;
        run_len   = '0;
        pix_left  = cfg_pix_total;
    endfunction

    // decode one byte; returns 1 when it yields a run
    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output pixel_run_t run);
        logic [PIX_W-1:0] n;
        run = '0;
        n = '0;
        if (st) restart_image();
        if (pix_left == '0) return 1'b0;
        if (dec_phase == PH_HEADER) begin
            if (hdr_left != '0) begin
                hdr_left = hdr_left - 8'd1;
                if (hdr_left == '0) dec_phase = PH_CONTROL;
                return 1'b0;
            end
            dec_phase = PH_CONTROL;
        end
        case (dec_phase)
            PH_RUN: begin
                dec_phase = PH_CONTROL;
                n = PIX_W'(run_len);
            end
            PH_LITERAL: begin
                if (lit_left != '0) lit_left = lit_left - 8'd1;
                if (lit_left == '0) dec_phase = PH_CONTROL;
                n = PIX_W'(1);
            end
            default: begin
                // control byte: top bit picks run or literal block
                if (b[7]) begin
                    run_len   = {1'b0, b[6:0]} + 8'd2;
                    dec_phase = PH_RUN;
                end else begin
                    lit_left  = {1'b0, b[6:0]} + 8'd1;
                    dec_phase = PH_LITERAL;
                end
                return 1'b0;
            end
        endcase
        // counts are cut to what is left of the image
        if (n > pix_left) n = pix_left;
        pix_left   = pix_left - n;
        run.colour = palette_rgb(b);
        run.count  = n[7:0];
        run.last   = (pix_left == '0);
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic script_row_t byte_row(input logic [7:0] b, input logic st);
        script_row_t row;
        row = '{kind: ROW_PREDICT, value: PIX_W'(b), start: st, reg_idx: 1'b0,
                has_run: 1'b0, run: '0};
        return row;
    endfunction

    function automatic script_row_t none_row(input logic [7:0] b, input logic st);
        script_row_t row;
        row = byte_row(b, st);
        row.kind = ROW_TYPED;
        return row;
    endfunction

    function automatic script_row_t run_row(input logic [7:0] b, input logic st,
                                            input logic [23:0] colour,
                                            input logic [7:0] count, input logic last);
        script_row_t row;
        row = none_row(b, st);
        row.has_run = 1'b1;
        row.run = '{colour: colour, count: count, last: last};
        return row;
    endfunction

    function automatic script_row_t write_row(input logic idx, input logic [PIX_W-1:0] val);
        script_row_t row;
        row = '{kind: ROW_WRITE, value: val, start: 1'b0, reg_idx: idx,
                has_run: 1'b0, run: '0};
        return row;
    endfunction

    // offer one item and wait for it to be taken; start flag comes from start_pending
    task automatic put_byte(input logic [7:0] b, output bit got, output pixel_run_t run);
        logic st;
        st = start_pending;
        start_pending = 1'b0;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        got = decode_byte(b, st, run);
        body_items++;
    endtask

    task automatic feed(input logic [7:0] b);
        bit got;
        pixel_run_t run;
        put_byte(b, got, run);
        if (got) pending_runs.push_back(run);
    endtask

    // stop offering and wait for every expected run plus the pipeline tail
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [PIX_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_HEADER_LENGTH) cfg_hdr_len = val[7:0];
        else cfg_pix_total = val;
    endtask

    // one image: header, then mostly well-formed blocks, sometimes noise or a cut-off
    task automatic send_image(input int budget);
        int  sent;
        int  kind;
        int  n;
        bit  quit;
        sent = 0;
        quit = 1'b0;
        if (start_pending) begin
            // start byte: header byte, or a control byte when there is no header
            feed(rand_byte());
            while (hdr_left != '0) feed(rand_byte());
        end else begin
            while (dec_phase == PH_HEADER && hdr_left != '0) feed(rand_byte());
        end
        while (pix_left != '0 && sent < budget && !quit) begin
            kind = $urandom_range(0, 19);
            if (kind < 9) begin
                // run block
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
                feed(8'h80 | 8'(n));
                feed(rand_byte());
                sent += 2;
            end else if (kind < 17) begin
                // literal block
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
                feed(8'(n));
                repeat (n + 1) feed(rand_byte());
                sent += n + 2;
            end else if (kind == 17) begin
                feed(rand_byte());
                sent += 1;
            end else if (kind == 18) begin
                quit = 1'b1;
            end else begin
                // literal block cut short by the next image
                n = $urandom_range(2, 20);
                feed(8'(n));
                repeat ($urandom_range(0, n - 1)) feed(rand_byte());
                sent += 1;
                quit = 1'b1;
            end
        end
        // trailing bytes, ignored once the image is complete
        repeat ($urandom_range(0, 3)) feed(rand_byte());
    endtask

    // result side: check each taken item, then decide next ready
    initial begin : result_side
        int stall_left;
        int hold_left;
        pixel_run_t want;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_runs.size() == 0) begin
                    $error("unexpected result item: colour %06h count %0d last %0b",
                           m_tdata[23:0], m_tdata[31:24], m_tlast);
                    error_count++;
                end else begin
                    want = pending_runs.pop_front();
                    if (m_tdata[23:0] !== want.colour) begin
                        $error("pixel_colour: expected %06h, got %06h", want.colour, m_tdata[23:0]);
                        error_count++;
                    end
                    if (m_tdata[31:24] !== want.count) begin
                        $error("repeat_count: expected %0d, got %0d", want.count, m_tdata[31:24]);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_image: expected %0b, got %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_go) begin
                // long hold-off so the decoder backs up into its input
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("rle_palette_image_decoder_top: mismatch");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        bit          got;
        bit          hold_done;
        pixel_run_t  run;
        int          images;
        int          pick;
        logic [7:0]  hdr_val;
        logic [PIX_W-1:0] pix_val;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_HEADER_LENGTH;
        cfg_wdata <= '0;
        error_count   = 0;
        body_items    = 0;
        idle_on       = 1'b1;
        start_pending = 1'b0;
        hold_go       = 1'b0;
        hold_done     = 1'b0;
        cfg_hdr_len   = HEADER_LENGTH_RESET;
        cfg_pix_total = IMAGE_PIXELS_RESET;
        restart_image();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: long header, large image, no start flag needed
        send_image(80);

        // directed table
        script.push_back(write_row(REG_HEADER_LENGTH, PIX_W'(2)));
        script.push_back(write_row(REG_IMAGE_PIXELS, PIX_W'(10)));
        script.push_back(none_row(8'h5A, 1'b1));
        script.push_back(none_row(8'hC3, 1'b0));
        script.push_back(none_row(8'h81, 1'b0));
        script.push_back(run_row(8'hFF, 1'b0, 24'hFFFFFF, 8'd3, 1'b0));
        script.push_back(none_row(8'h02, 1'b0));
        script.push_back(run_row(8'h00, 1'b0, 24'h000000, 8'd1, 1'b0));
        script.push_back(run_row(8'h80, 1'b0, 24'h880000, 8'd1, 1'b0));
        script.push_back(byte_row(8'h7F, 1'b0));
        script.push_back(none_row(8'hFF, 1'b0));
        // run cut to the pixels left, completing the image
        script.push_back(run_row(8'h80, 1'b0, 24'h880000, 8'd4, 1'b1));
        script.push_back(none_row(8'h00, 1'b0));
        script.push_back(none_row(8'h81, 1'b0));
        // register writes mid-image wait for the next start
        script.push_back(byte_row(8'h11, 1'b1));
        script.push_back(byte_row(8'h22, 1'b0));
        script.push_back(byte_row(8'h7F, 1'b0));
        script.push_back(byte_row(8'h3C, 1'b0));
        script.push_back(write_row(REG_IMAGE_PIXELS, PIX_W'(1)));
        script.push_back(write_row(REG_HEADER_LENGTH, PIX_W'(0)));
        script.push_back(byte_row(8'h96, 1'b0));
        // no header: the start byte is a control byte
        script.push_back(none_row(8'h81, 1'b1));
        script.push_back(run_row(8'h00, 1'b0, 24'h000000, 8'd1, 1'b1));
        script.push_back(none_row(8'h80, 1'b0));
        // literal block longer than the image
        script.push_back(write_row(REG_IMAGE_PIXELS, PIX_W'(2)));
        script.push_back(byte_row(8'h03, 1'b1));
        script.push_back(byte_row(8'h44, 1'b0));
        script.push_back(run_row(8'h00, 1'b0, 24'h000000, 8'd1, 1'b1));
        script.push_back(none_row(8'hFF, 1'b0));
        // zero pixel total: complete from the start
        script.push_back(write_row(REG_IMAGE_PIXELS, PIX_W'(0)));
        script.push_back(none_row(8'h80, 1'b1));
        script.push_back(none_row(8'hFF, 1'b0));

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_WRITE: begin
                    write_reg(script[i].reg_idx, script[i].value);
                end
                ROW_PREDICT: begin
                    start_pending = script[i].start;
                    feed(script[i].value[7:0]);
                end
                default: begin
                    start_pending = script[i].start;
                    put_byte(script[i].value[7:0], got, run);
                    if (script[i].has_run) pending_runs.push_back(script[i].run);
                end
            endcase
        end

        // random phases of register settings and images
        while (body_items < BODY_TARGET) begin
            if (body_items >= CALM_FROM) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            if (!hold_done && body_items > 250) begin
                // long receiver hold while a literal block keeps arriving
                hold_done = 1'b1;
                write_reg(REG_HEADER_LENGTH, PIX_W'(0));
                write_reg(REG_IMAGE_PIXELS, PIX_W'(300));
                hold_go = 1'b1;
                start_pending = 1'b1;
                feed(8'h7F);
                repeat (128) feed(rand_byte());
            end else begin
                pick = $urandom_range(0, 9);
                hdr_val = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd68 :
                          8'($urandom_range(0, 7));
                pick = $urandom_range(0, 9);
                pix_val = (pick == 0) ? PIX_W'(1) : (pick == 1) ? PIX_W'(131071) :
                          (pick == 2) ? PIX_W'($urandom_range(1, 131071)) :
                          PIX_W'($urandom_range(1, 80));
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(REG_HEADER_LENGTH, PIX_W'(hdr_val));
                    write_reg(REG_IMAGE_PIXELS, pix_val);
                end else begin
                    write_reg(REG_IMAGE_PIXELS, pix_val);
                    write_reg(REG_HEADER_LENGTH, PIX_W'(hdr_val));
                end
                images = $urandom_range(1, 3);
                repeat (images) begin
                    if (body_items < BODY_TARGET) begin
                        start_pending = 1'b1;
                        send_image($urandom_range(30, 80));
                    end
                end
            end
        end

        idle_on = 1'b0;
        drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("rle_palette_image_decoder_top: match");
        end else begin
            $display("rle_palette_image_decoder_top: mismatch");
        end
        $finish;
    end

endmodule
